@@ rtl/pn3d_pkg.sv @@
`default_nettype none
package pn3d_pkg;

  localparam int unsigned OutOffset = 19052;
  localparam int unsigned OutScale = 440;

  // Register stages from the start transfer to the result.
  localparam int Stages = 8;

  // Fixed permutation table, 256 entries.
  localparam logic [7:0] PERM_ROM [256] = '{
    8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95, 8'd96, 8'd53,
    8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30, 8'd69, 8'd142, 8'd8, 8'd99,
    8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190, 8'd6, 8'd148, 8'd247, 8'd120, 8'd234, 8'd75,
    8'd0, 8'd26, 8'd197, 8'd62, 8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32,
    8'd57, 8'd177, 8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87, 8'd174, 8'd20, 8'd125, 8'd136,
    8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48, 8'd27, 8'd166,
    8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122, 8'd60, 8'd211, 8'd133, 8'd230,
    8'd220, 8'd105, 8'd92, 8'd41, 8'd55, 8'd46, 8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54,
    8'd65, 8'd25, 8'd63, 8'd161, 8'd1, 8'd216, 8'd80, 8'd73, 8'd209, 8'd76, 8'd132, 8'd187,
    8'd208, 8'd89, 8'd18, 8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
    8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217, 8'd226, 8'd250,
    8'd124, 8'd123, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126, 8'd255, 8'd82, 8'd85, 8'd212,
    8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16, 8'd58, 8'd17, 8'd182, 8'd189, 8'd28, 8'd42,
    8'd223, 8'd183, 8'd170, 8'd213, 8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70,
    8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9, 8'd129, 8'd22, 8'd39, 8'd253,
    8'd19, 8'd98, 8'd108, 8'd110, 8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
    8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193, 8'd238, 8'd210, 8'd144, 8'd12,
    8'd191, 8'd179, 8'd162, 8'd241, 8'd81, 8'd51, 8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107,
    8'd49, 8'd192, 8'd214, 8'd31, 8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84, 8'd204, 8'd176,
    8'd115, 8'd121, 8'd50, 8'd45, 8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
    8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141, 8'd128, 8'd195, 8'd78, 8'd66,
    8'd215, 8'd61, 8'd156, 8'd180
  };

  typedef logic [15:0] word_t;

  // Scales a value by (frac + 1) / 65536.
  function automatic word_t mul_frac(input word_t val, input word_t frac);
    logic [32:0] prod;
    prod = {17'd0, val} * ({17'd0, frac} + 33'd1);
    return prod[31:16];
  endfunction

  // Averages two signed words: halves their sum, rounding down, then adds one when a is odd.
  function automatic word_t avg_odd(input word_t a, input word_t b);
    logic [16:0] sum;
    sum = {a[15], a} + {b[15], b};
    return sum[16:1] + {15'd0, a[0]};
  endfunction

  // Gradient of one corner from the low four hash bits.
  function automatic word_t grad(input logic [7:0] hash, input word_t x, input word_t y,
                                 input word_t z);
    logic [3:0] h;
    word_t u;
    word_t v;
    h = hash[3:0];
    u = (h < 4'd8) ? x : y;
    v = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
    if (h[0]) u = 16'd0 - u;
    if (h[1]) v = 16'd0 - v;
    return avg_odd(u, v);
  endfunction

endpackage
`default_nettype wire

@@ rtl/perlin_noise_3d_16bit_core.sv @@
`default_nettype none
// 3D gradient noise core. One point is accepted per cycle (busy is always low), and
// its noise value appears on noise_value with valid high after it has passed through
// the eight register stages of the hash, ease, lerp and scaling pipeline. The
// receiver cannot stall: every result is shown for one cycle only.
module perlin_noise_3d_16bit_core
  import pn3d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] coord_x,
  input  wire logic [31:0] coord_y,
  input  wire logic [31:0] coord_z,
  output logic             valid,
  output logic [15:0]      noise_value
);

  logic [Stages-1:0] vld;

  // Stage 1: first hash level and ease inputs.
  logic [7:0] s1_ha, s1_hb, s1_cz;
  word_t s1_fu, s1_fv, s1_fw, s1_eju, s1_ejv, s1_ejw;
  // Stage 2: second hash level and eased fractions.
  logic [7:0] s2_haa, s2_hab, s2_hba, s2_hbb;
  word_t s2_fu, s2_fv, s2_fw, s2_eu, s2_ev, s2_ew;
  // Stage 3: corner hashes.
  logic [7:0] s3_h [8];
  word_t s3_fu, s3_fv, s3_fw, s3_eu, s3_ev, s3_ew;
  // Stage 4: corner gradients.
  word_t s4_g [8];
  word_t s4_eu, s4_ev, s4_ew;
  // Stages 5 to 7: lerp tree.
  word_t s5_r [4];
  word_t s5_ev, s5_ew;
  word_t s6_s [2];
  word_t s6_ew;
  word_t s7_raw;
  logic [31:0] s8_pan;

  function automatic word_t ease_in(input word_t i);
    return i[15] ? 16'hFFFF - i : i;
  endfunction

  function automatic word_t ease_out(input word_t i, input word_t j);
    word_t m;
    word_t r;
    m = mul_frac(j, j);
    r = {m[14:0], 1'b0};
    return i[15] ? 16'hFFFF - r : r;
  endfunction

  function automatic word_t lerp(input word_t a, input word_t b, input word_t f);
    if ($signed(b) > $signed(a)) return a + mul_frac(b - a, f);
    return a - mul_frac(a - b, f);
  endfunction

  assign busy = 1'b0;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[Stages-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] ans;
    logic [7:0] xp1;
    ans = 32'd0;
    xp1 = coord_x[23:16] + 8'd1;
    // Stage 1.
    s1_ha  <= PERM_ROM[coord_x[23:16]] + coord_y[23:16];
    s1_hb  <= PERM_ROM[xp1] + coord_y[23:16];
    s1_cz  <= coord_z[23:16];
    s1_fu  <= coord_x[15:0];
    s1_fv  <= coord_y[15:0];
    s1_fw  <= coord_z[15:0];
    s1_eju <= ease_in(coord_x[15:0]);
    s1_ejv <= ease_in(coord_y[15:0]);
    s1_ejw <= ease_in(coord_z[15:0]);
    // Stage 2.
    s2_haa <= PERM_ROM[s1_ha] + s1_cz;
    s2_hab <= PERM_ROM[s1_ha + 8'd1] + s1_cz;
    s2_hba <= PERM_ROM[s1_hb] + s1_cz;
    s2_hbb <= PERM_ROM[s1_hb + 8'd1] + s1_cz;
    s2_fu  <= s1_fu;
    s2_fv  <= s1_fv;
    s2_fw  <= s1_fw;
    s2_eu  <= ease_out(s1_fu, s1_eju);
    s2_ev  <= ease_out(s1_fv, s1_ejv);
    s2_ew  <= ease_out(s1_fw, s1_ejw);
    // Stage 3.
    s3_h[0] <= PERM_ROM[s2_haa];
    s3_h[1] <= PERM_ROM[s2_hba];
    s3_h[2] <= PERM_ROM[s2_hab];
    s3_h[3] <= PERM_ROM[s2_hbb];
    s3_h[4] <= PERM_ROM[s2_haa + 8'd1];
    s3_h[5] <= PERM_ROM[s2_hba + 8'd1];
    s3_h[6] <= PERM_ROM[s2_hab + 8'd1];
    s3_h[7] <= PERM_ROM[s2_hbb + 8'd1];
    s3_fu <= s2_fu;
    s3_fv <= s2_fv;
    s3_fw <= s2_fw;
    s3_eu <= s2_eu;
    s3_ev <= s2_ev;
    s3_ew <= s2_ew;
    // Stage 4: gradients at the eight corners.
    for (int k = 0; k < 8; k++) begin
      s4_g[k] <= grad(s3_h[k],
                      k[0] ? {1'b1, s3_fu[15:1]} : {1'b0, s3_fu[15:1]},
                      k[1] ? {1'b1, s3_fv[15:1]} : {1'b0, s3_fv[15:1]},
                      k[2] ? {1'b1, s3_fw[15:1]} : {1'b0, s3_fw[15:1]});
    end
    s4_eu <= s3_eu;
    s4_ev <= s3_ev;
    s4_ew <= s3_ew;
    // Stage 5: lerp along x.
    for (int k = 0; k < 4; k++) begin
      s5_r[k] <= lerp(s4_g[2*k], s4_g[2*k+1], s4_eu);
    end
    s5_ev <= s4_ev;
    s5_ew <= s4_ew;
    // Stage 6: lerp along y.
    s6_s[0] <= lerp(s5_r[0], s5_r[1], s5_ev);
    s6_s[1] <= lerp(s5_r[2], s5_r[3], s5_ev);
    s6_ew <= s5_ew;
    // Stage 7: lerp along z.
    s7_raw <= lerp(s6_s[0], s6_s[1], s6_ew);
    // Stage 8: offset and scale.
    ans = {{16{s7_raw[15]}}, s7_raw} + 32'(OutOffset);
    s8_pan <= ans * 32'(OutScale);
  end

  assign valid = vld[Stages-1];
  assign noise_value = s8_pan[23:8];

endmodule
`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import pn3d_pkg::*;

  // Expected noise values, oldest first, and the mismatch count.
  class noise_scoreboard;
    logic [15:0] pending_q[$];
    int unsigned errors;
    int unsigned checked;

    function void note_point(input logic [15:0] expected);
      pending_q.push_back(expected);
    endfunction

    function void check_noise(input logic [15:0] actual);
      logic [15:0] expected;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected noise_value %h", actual);
        return;
      end
      expected = pending_q.pop_front();
      checked++;
      if (expected !== actual) begin
        errors++;
        if (errors <= 10)
          $display("noise_value mismatch: expected %h, actual %h", expected, actual);
      end
    endfunction
  endclass

  localparam int unsigned LATENCY = 8;
  localparam longint unsigned CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [31:0] coord_x = '0;
  logic [31:0] coord_y = '0;
  logic [31:0] coord_z = '0;
  logic valid;
  logic [15:0] noise_value;

  noise_scoreboard sb;
  int idle_pct;
  longint unsigned cycles = 0;

  perlin_noise_3d_16bit_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .valid(valid), .noise_value(noise_value)
  );

  always #1 clk = ~clk;

  // Predictor helpers, mirroring the block's arithmetic with wider intermediate sums and products.
  function automatic logic [7:0] hash_of(input logic [7:0] idx);
    return PERM_ROM[idx];
  endfunction

  function automatic logic [15:0] frac_scale(input logic [15:0] v, input logic [15:0] f);
    logic [33:0] p;
    p = {18'd0, v} * ({18'd0, f} + 34'd1);
    return p[31:16];
  endfunction

  function automatic logic [15:0] ease_curve(input logic [15:0] i);
    logic [15:0] j;
    logic [15:0] m;
    logic [15:0] r;
    j = i[15] ? 16'hFFFF - i : i;
    m = frac_scale(j, j);
    r = {m[14:0], 1'b0};
    return i[15] ? 16'hFFFF - r : r;
  endfunction

  function automatic logic [15:0] merge_avg(input logic [15:0] a, input logic [15:0] b);
    logic signed [17:0] s;
    s = $signed({{2{a[15]}}, a}) + $signed({{2{b[15]}}, b});
    return s[16:1] + {15'd0, a[0]};
  endfunction

  function automatic logic [15:0] corner_slope(input logic [7:0] hash, input logic [15:0] x,
                                               input logic [15:0] y, input logic [15:0] z);
    logic [3:0] h;
    logic [15:0] u;
    logic [15:0] v;
    h = hash[3:0];
    u = (h < 8) ? x : y;
    v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
    if (h[0]) u = -u;
    if (h[1]) v = -v;
    return merge_avg(u, v);
  endfunction

  function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                        input logic [15:0] f);
    if ($signed(b) > $signed(a)) return a + frac_scale(b - a, f);
    return a - frac_scale(a - b, f);
  endfunction

  function automatic logic [15:0] predict_noise(input logic [31:0] x, input logic [31:0] y,
                                                input logic [31:0] z);
    logic [7:0] cy;
    logic [7:0] cz;
    logic [7:0] ha;
    logic [7:0] hb;
    logic [7:0] haa;
    logic [7:0] hab;
    logic [7:0] hba;
    logic [7:0] hbb;
    logic [15:0] xx;
    logic [15:0] yy;
    logic [15:0] zz;
    logic [15:0] xm;
    logic [15:0] ym;
    logic [15:0] zm;
    logic [15:0] eu;
    logic [15:0] r1;
    logic [15:0] r2;
    logic [15:0] r3;
    logic [15:0] r4;
    logic [15:0] raw;
    logic [31:0] scaled;
    cy = y[23:16];
    cz = z[23:16];
    ha = hash_of(x[23:16]) + cy;
    hb = hash_of(x[23:16] + 8'd1) + cy;
    haa = hash_of(ha) + cz;
    hab = hash_of(ha + 8'd1) + cz;
    hba = hash_of(hb) + cz;
    hbb = hash_of(hb + 8'd1) + cz;
    xx = {1'b0, x[15:1]};
    yy = {1'b0, y[15:1]};
    zz = {1'b0, z[15:1]};
    xm = xx ^ 16'h8000;
    ym = yy ^ 16'h8000;
    zm = zz ^ 16'h8000;
    eu = ease_curve(x[15:0]);
    r1 = blend(corner_slope(hash_of(haa), xx, yy, zz),
               corner_slope(hash_of(hba), xm, yy, zz), eu);
    r2 = blend(corner_slope(hash_of(hab), xx, ym, zz),
               corner_slope(hash_of(hbb), xm, ym, zz), eu);
    r3 = blend(corner_slope(hash_of(haa + 8'd1), xx, yy, zm),
               corner_slope(hash_of(hba + 8'd1), xm, yy, zm), eu);
    r4 = blend(corner_slope(hash_of(hab + 8'd1), xx, ym, zm),
               corner_slope(hash_of(hbb + 8'd1), xm, ym, zm), eu);
    raw = blend(blend(r1, r2, ease_curve(y[15:0])), blend(r3, r4, ease_curve(y[15:0])),
                ease_curve(z[15:0]));
    scaled = ({{16{raw[15]}}, raw} + 32'd19052) * 32'd440;
    return scaled[23:8];
  endfunction

  // Presents one point and holds it until the block takes the transfer.
  task automatic send_point(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    do @(posedge clk); while (busy);
    sb.note_point(predict_noise(x, y, z));
  endtask

  // Mostly random coordinates, sometimes pinned to cell edges or the fraction midpoint.
  function automatic logic [31:0] pick_coord();
    logic [31:0] c;
    c = $urandom();
    case ($urandom_range(7))
      0: c[15:0] = 16'h0000;
      1: c[15:0] = 16'hFFFF;
      2: c[15:0] = 16'h8000 - 16'($urandom_range(1));
      default: ;
    endcase
    return c;
  endfunction

  task automatic run_phase(input int pct, input int count);
    idle_pct = pct;
    repeat (count) send_point(pick_coord(), pick_coord(), pick_coord());
  endtask

  // Results are taken on every edge where valid is high.
  always @(posedge clk) begin
    if (!rst && valid) sb.check_noise(noise_value);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    logic [31:0] edge_vals[6];
    sb = new();
    idle_pct = 0;
    edge_vals = '{32'h0, 32'hFFFFFFFF, 32'h00FF_FFFF, 32'hFF00_0000, 32'h0000_8000,
                  32'h0001_7FFF};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes of every coordinate and lattice wrap points.
    for (int i = 0; i < 6; i++) send_point(edge_vals[i], edge_vals[i], edge_vals[i]);
    for (int i = 0; i < 6; i++) send_point(edge_vals[i], edge_vals[(i + 2) % 6],
                                           edge_vals[(i + 4) % 6]);
    send_point(32'h00FF_0000, 32'h0000_FFFF, 32'h8000_0001);

    run_phase(0, 500);
    run_phase(85, 250);
    // Let the pipeline drain completely before continuing.
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    run_phase(6, 550);
    run_phase(0, 300);
    run_phase(85, 250);
    start <= 1'b0;

    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    $display("Checked %0d noise values over random and edge coordinates,", sb.checked);
    $display("with back-to-back, sparse and lightly gapped start traffic.");
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", sb.errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ perlin_noise_3d_16bit_core.f @@
rtl/pn3d_pkg.sv
rtl/perlin_noise_3d_16bit_core.sv
test/testbench.sv
